// ===== rtl/lts_pkg.sv =====
// Shared types, codes and constants for the line track state updater.
package lts_pkg;

  // Track status codes.
  localparam logic [1:0] ST_UNSEEN    = 2'd0;
  localparam logic [1:0] ST_CURRENT   = 2'd1;
  localparam logic [1:0] ST_COMPLETED = 2'd2;

  // Line position codes.
  localparam logic [1:0] POS_LEFT   = 2'd0;
  localparam logic [1:0] POS_CENTER = 2'd1;
  localparam logic [1:0] POS_RIGHT  = 2'd2;

  // First-side codes.
  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_EDGE_THRESHOLD  = 1'b0;
  localparam logic CFG_COMPLETED_DELAY = 1'b1;

  // Register reset values and field widths.
  localparam int          CFG_DATA_W          = 32;
  localparam int          DIST_W              = 16;
  localparam int          NOW_W               = 32;
  localparam int          DELAY_W             = 32;
  localparam logic [15:0] EDGE_THRESHOLD_RST  = 16'd20;
  localparam logic [31:0] COMPLETED_DELAY_RST = 32'd1000;

  // Default width of the wrapping time arithmetic.
  localparam int TIME_BITS_DEF = 32;

  // One input item.
  typedef struct packed {
    logic [4:0]  line_sensors;
    logic [15:0] distance_left;
    logic [15:0] distance_right;
    logic [31:0] now_ms;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0] track_status;
    logic [1:0] line_position;
  } out_item_t;

  // Tracking state apart from the last-seen time.
  typedef struct packed {
    logic [1:0] status;
    logic [1:0] position;
    logic [1:0] first_side;
    logic       crossed;
  } track_state_t;

endpackage

// ===== rtl/lts_decide.sv =====
// Next-state logic for one sensor sample: status, position, side and crossing.
module lts_decide #(
  parameter int TIME_BITS = lts_pkg::TIME_BITS_DEF
) (
  input  lts_pkg::in_item_t     item,
  input  lts_pkg::track_state_t st,
  input  logic [TIME_BITS-1:0]  last_seen,
  input  logic [15:0]           edge_threshold,
  input  logic [31:0]           completed_delay,
  output lts_pkg::track_state_t st_nxt,
  output logic [TIME_BITS-1:0]  last_seen_nxt
);

  localparam int CW = (TIME_BITS > lts_pkg::NOW_W) ? TIME_BITS : lts_pkg::NOW_W;

  logic [4:0]           s;
  logic                 any_lit;
  logic                 edge_seen;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] diff;
  logic                 quiet_expired;
  logic [1:0]           side_nxt;
  logic [1:0]           pull_right;
  logic [1:0]           pull_left;

  assign s       = item.line_sensors;
  assign any_lit = |s;
  assign edge_seen = (item.distance_left > edge_threshold) ||
                     (item.distance_right > edge_threshold);

  // Wrapping time since the line was last seen.
  assign now_t         = TIME_BITS'(CW'(item.now_ms));
  assign diff          = now_t - last_seen;
  assign quiet_expired = CW'(diff) > CW'(completed_delay);

  // The side that saw the line first is fixed on the first classified sample.
  assign side_nxt = (st.first_side != lts_pkg::SIDE_NONE) ? st.first_side :
                    ((s[3] || s[4]) ? lts_pkg::SIDE_RIGHT : lts_pkg::SIDE_LEFT);

  // Weighted pull to each side: outer sensors count twice.
  assign pull_right = {1'b0, s[3]} + {s[4], 1'b0};
  assign pull_left  = {1'b0, s[1]} + {s[0], 1'b0};

  always_comb begin
    st_nxt        = st;
    last_seen_nxt = last_seen;
    if (st.status == lts_pkg::ST_COMPLETED) begin
      // Finished track holds everything.
    end else if (st.status == lts_pkg::ST_UNSEEN && !s[0] && !s[1]) begin
      // Before the line is found, only the left sensors can start tracking.
    end else if (!any_lit) begin
      if (st.status == lts_pkg::ST_CURRENT && quiet_expired) begin
        st_nxt.status = lts_pkg::ST_COMPLETED;
      end
    end else if (!edge_seen) begin
      last_seen_nxt     = now_t;
      st_nxt.status     = lts_pkg::ST_CURRENT;
      st_nxt.first_side = side_nxt;
      if (&s) begin
        st_nxt.position = lts_pkg::POS_LEFT;
      end else if (s == 5'b11011) begin
        st_nxt.position = lts_pkg::POS_CENTER;
      end else if (!st.crossed) begin
        // Still approaching the line: hold center until the first side clears.
        st_nxt.position = lts_pkg::POS_CENTER;
        if ((!s[0] && side_nxt == lts_pkg::SIDE_LEFT) ||
            (!s[4] && side_nxt == lts_pkg::SIDE_RIGHT)) begin
          st_nxt.crossed = 1'b1;
        end
      end else if ((&s[3:0]) || (&s[4:1])) begin
        // Intersection: four adjacent sensors lit.
        st_nxt.position = s[0] ? lts_pkg::POS_RIGHT : lts_pkg::POS_LEFT;
      end else if (pull_right > pull_left) begin
        st_nxt.position = lts_pkg::POS_RIGHT;
      end else if (pull_right < pull_left) begin
        st_nxt.position = lts_pkg::POS_LEFT;
      end else begin
        st_nxt.position = lts_pkg::POS_CENTER;
      end
    end
  end

endmodule

// ===== rtl/line_track_state_updater.sv =====
// Top level of the line track state updater: handshakes, registers and state.
//
// The block takes one sensor sample per clock cycle while the output side is
// not stalled, and returns one result item (track status and line position
// after that sample) for each. An accepted item is held in an input register;
// when the result register is free or being taken, the decision logic updates
// the tracking state and loads the result register from the held item. One
// item per cycle is sustained while results are taken; the figure is set by
// the state update loop, which closes through the wrapping time subtract and
// the delay compare. A stalled result holds its input register, and both
// stall together without losing an item. Configuration writes take effect at
// once and are meant to happen only while the block is idle.
module line_track_state_updater #(
  parameter int TIME_BITS = lts_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lts_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lts_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [lts_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic                  in_vld_r;
  lts_pkg::in_item_t     in_item_r;
  logic                  out_vld_r;
  lts_pkg::out_item_t    out_item_r;
  lts_pkg::track_state_t st_r, st_nxt;
  logic [TIME_BITS-1:0]  last_seen_r, last_seen_nxt;
  logic [15:0]           edge_threshold_r;
  logic [31:0]           completed_delay_r;
  logic                  advance;

  // The held item moves on when the result register is free or being taken.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_threshold_r  <= lts_pkg::EDGE_THRESHOLD_RST;
      completed_delay_r <= lts_pkg::COMPLETED_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lts_pkg::CFG_EDGE_THRESHOLD:  edge_threshold_r  <= cfg_wdata[15:0];
        lts_pkg::CFG_COMPLETED_DELAY: completed_delay_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  lts_decide #(
    .TIME_BITS (TIME_BITS)
  ) u_decide (
    .item            (in_item_r),
    .st              (st_r),
    .last_seen       (last_seen_r),
    .edge_threshold  (edge_threshold_r),
    .completed_delay (completed_delay_r),
    .st_nxt          (st_nxt),
    .last_seen_nxt   (last_seen_nxt)
  );

  // Tracking state, updated once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.status     <= lts_pkg::ST_UNSEEN;
      st_r.position   <= lts_pkg::POS_CENTER;
      st_r.first_side <= lts_pkg::SIDE_NONE;
      st_r.crossed    <= 1'b0;
      last_seen_r     <= '0;
    end else if (advance) begin
      st_r        <= st_nxt;
      last_seen_r <= last_seen_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r.track_status  <= st_nxt.status;
      out_item_r.line_position <= st_nxt.position;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule

// ===== rtl/lts_checker.sv =====
// Port-level checks for the line track state updater, bound to the top level.
module lts_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input lts_pkg::out_item_t out_data
);

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An empty result register never holds back the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A track that was never seen still reports the center position.
  a_unseen_center: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.track_status == lts_pkg::ST_UNSEEN |->
      out_data.line_position == lts_pkg::POS_CENTER)
    else $error("unseen track reports off-center position");

endmodule

bind line_track_state_updater lts_checker u_lts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
